@@ hdl/srs_pkg.sv @@
// srs_pkg: shared types and constants for the stable rank sorter
// used by srs_cell and stable_rank_sorter; no dependencies

package srs_pkg;

  localparam int DATA_W = 32;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the broadcast value, shifting larger entries right
    logic shf;   // shift the whole chain one slot toward cell 0
  } srs_ctl_t;

  // contents of one cell
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] val;
  } srs_slot_t;

endpackage

@@ hdl/srs_cell.sv @@
// srs_cell: one slot of the insertion-sort chain
// depends on srs_pkg (srs_ctl_t, srs_slot_t, DATA_W)

module srs_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  srs_pkg::srs_ctl_t                ctl,
  input  logic signed [srs_pkg::DATA_W-1:0] ins_val,
  input  srs_pkg::srs_slot_t               left_slot,
  input  logic                             left_gt,
  input  srs_pkg::srs_slot_t               right_slot,
  output srs_pkg::srs_slot_t               slot,
  output logic                             gt
);
  import srs_pkg::*;

  logic                     vld_r, vld_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;

  // an empty cell counts as larger than anything; equal values stay put,
  // so a later arrival lands behind earlier equal ones
  assign gt = !vld_r || (val_r > ins_val);

  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (ctl.ins) begin
      if (left_gt) begin
        vld_nxt = left_slot.vld;
        val_nxt = left_slot.val;
      end else if (gt) begin
        vld_nxt = 1'b1;
        val_nxt = ins_val;
      end
    end else if (ctl.shf) begin
      vld_nxt = right_slot.vld;
      val_nxt = right_slot.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign slot.vld = vld_r;
  assign slot.val = val_r;

endmodule

@@ hdl/stable_rank_sorter.sv @@
// stable_rank_sorter: top level, chain of srs_cell slots plus load/emit control
// depends on srs_pkg and srs_cell
//
// usage
//   input channel (in_valid/in_ready): one signed value per item, in_last on
//   the final item of a list. up to MAX_ITEMS values are kept; further items
//   are dropped and the run is flagged with out_overflow.
//   output channel (out_valid/out_ready): after the last item the stored
//   values come out in ascending order, equal values in arrival order,
//   out_final_res marking the final one of the run.
// timing
//   loading accepts one item per cycle; each item is inserted into its sorted
//   place in the cell chain in the cycle it is accepted.
//   the first result is valid the cycle after the last item is accepted and
//   results then leave one per cycle while out_ready is high, each taken
//   result shifting the whole chain one slot toward the head cell.
//   in_ready is low while a run is being emitted and rises again the cycle
//   after the final result is taken.
// reset
//   synchronous active-low rst_n empties the chain and clears the flags.
//   a stalled receiver simply freezes the chain; out_* hold until taken.

module stable_rank_sorter #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [srs_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [srs_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_final_res,
  output logic                              out_overflow
);
  import srs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] remain_r;
  logic             drop_r;

  srs_ctl_t  ctl;
  srs_slot_t slots [MAX_ITEMS];
  logic      gts   [MAX_ITEMS];

  logic in_acc, out_acc, room;

  assign in_ready = (state_r == ST_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign room     = (count_r < CNT_W'(MAX_ITEMS));

  assign ctl.ins = in_acc && room;
  assign ctl.shf = out_acc;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
      srs_slot_t left_s, right_s;
      logic      left_g;
      if (gi == 0) begin : g_head
        assign left_s = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_s = slots[gi-1];
        assign left_g = gts[gi-1];
      end
      if (gi == MAX_ITEMS - 1) begin : g_tail
        assign right_s = '0;
      end else begin : g_body
        assign right_s = slots[gi+1];
      end
      srs_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .ins_val    (in_value),
        .left_slot  (left_s),
        .left_gt    (left_g),
        .right_slot (right_s),
        .slot       (slots[gi]),
        .gt         (gts[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      remain_r <= '0;
      drop_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              drop_r <= 1'b1;
            end
            if (in_last) begin
              state_r  <= ST_EMIT;
              remain_r <= count_r + CNT_W'(room);
            end
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            remain_r <= remain_r - CNT_W'(1);
            if (remain_r == CNT_W'(1)) begin
              state_r <= ST_LOAD;
              count_r <= '0;
              drop_r  <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid        = (state_r == ST_EMIT);
  assign out_sorted_value = slots[0].val;
  assign out_final_res    = (remain_r == CNT_W'(1));
  assign out_overflow     = drop_r;

  // head cell must hold an element whenever a result is offered
  a_head_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slots[0].vld)
    else $error("result offered from empty head cell");

  // a run always has at least one element and never exceeds the chain
  a_remain_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (remain_r != '0) && (remain_r <= CNT_W'(MAX_ITEMS)))
    else $error("remaining count out of range");

  // count of stored elements never exceeds capacity
  a_count_cap : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("element count beyond capacity");

  // closing item starts the run on the next cycle
  a_last_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid && !in_ready)
    else $error("run did not start after last item");

  // cell just past the stored count is empty while loading
  a_fill_match : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && room |-> !slots[count_r[$clog2(MAX_ITEMS)-1:0]].vld)
    else $error("chain occupancy does not match count");

endmodule

@@ bench/stable_rank_sorter_tb.sv @@
// stable_rank_sorter_tb: self-checking bench for the stable rank sorter, streams lists
// through the input channel and checks every sorted run against an in-bench stable sort
// depends on srs_pkg and stable_rank_sorter
`timescale 1ns / 1ps

module stable_rank_sorter_tb;
  import srs_pkg::*;

  localparam int MAX_ITEMS  = 64;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;
  localparam int RAND_ITEMS = 170;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } list_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     final_res;
    logic                     overflow;
  } sorted_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_final_res;
  logic                     out_overflow;

  list_item_t               pending_items[$];
  logic signed [DATA_W-1:0] list_store[$];
  logic                     list_dropped = 1'b0;
  sorted_word_t             sorted_expect[$];
  int                       err_count = 0;
  int                       results_seen = 0;

  stable_rank_sorter #(.MAX_ITEMS(MAX_ITEMS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflow     (out_overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // stores an accepted item; on the closing item the stable sorted run is queued
  task automatic absorb_item(input logic signed [DATA_W-1:0] v, input logic is_last);
    logic signed [DATA_W-1:0] run[$];
    logic signed [DATA_W-1:0] key;
    sorted_word_t             word;
    int                       j;
    if (list_store.size() < MAX_ITEMS) list_store.push_back(v);
    else list_dropped = 1'b1;
    if (is_last) begin
      run = list_store;
      // insertion sort moves only strictly larger values, so equal ones keep arrival order
      for (int i = 1; i < run.size(); i++) begin
        key = run[i];
        j = i - 1;
        while (j >= 0 && run[j] > key) begin
          run[j+1] = run[j];
          j--;
        end
        run[j+1] = key;
      end
      for (int i = 0; i < run.size(); i++) begin
        word.value     = run[i];
        word.final_res = (i == run.size() - 1);
        word.overflow  = list_dropped;
        sorted_expect.push_back(word);
      end
      list_store.delete();
      list_dropped = 1'b0;
    end
  endtask

  task automatic add_item(input logic signed [DATA_W-1:0] v, input logic is_last);
    list_item_t it;
    it.value = v;
    it.last  = is_last;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int sel;
    int near_zero;
    sel = $urandom_range(0, 9);
    near_zero = int'($urandom_range(0, 6)) - 3;
    case (sel)
      5, 6, 7: pick_value = near_zero;
      8:       pick_value = 32'sh8000_0000;
      9:       pick_value = 32'sh7fff_ffff;
      default: pick_value = $urandom;
    endcase
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin : drive_items
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
      in_last  <= 1'b0;
    end else begin
      if (fire) begin
        absorb_item(in_value, in_last);
        void'(pending_items.pop_front());
      end
      if (in_valid && !fire) begin
        // hold the offered item until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_value <= pending_items[0].value;
        in_last  <= pending_items[0].last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches between randomly drawn modes, plus one long hold
  int  rx_mode = 0;
  int  rx_phase = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin : check_results
    sorted_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (sorted_expect.size() == 0) begin
          $display("%0t: unexpected result value %0d final %0b overflow %0b", $time,
                   out_sorted_value, out_final_res, out_overflow);
          err_count++;
        end else begin
          want = sorted_expect.pop_front();
          if (out_sorted_value !== want.value) begin
            $display("%0t: sorted_value expected %0d actual %0d", $time, want.value,
                     out_sorted_value);
            err_count++;
          end
          if (out_final_res !== want.final_res) begin
            $display("%0t: final_res expected %0b actual %0b", $time, want.final_res,
                     out_final_res);
            err_count++;
          end
          if (out_overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     out_overflow);
            err_count++;
          end
        end
      end
      rx_phase++;
      if (rx_phase % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (!hold_done && results_seen >= 30 && out_valid) begin
        hold_done = 1'b1;
        hold_cnt  = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= rx_phase[2];
        endcase
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("stable_rank_sorter regression: fail");
      $finish;
    end
  end

  initial begin
    int total;
    int list_no;
    int len;
    // single-element lists at both extremes
    add_item(32'sh8000_0000, 1'b1);
    add_item(32'sh7fff_ffff, 1'b1);
    // mixed extremes with repeats
    add_item(0, 1'b0);
    add_item(-1, 1'b0);
    add_item(1, 1'b0);
    add_item(32'sh7fff_ffff, 1'b0);
    add_item(32'sh8000_0000, 1'b0);
    add_item(-1, 1'b0);
    add_item(0, 1'b0);
    add_item(32'sh7fff_ffff, 1'b0);
    add_item(32'sh8000_0000, 1'b0);
    add_item(5, 1'b1);
    // descending with pairs, then already ascending
    add_item(3, 1'b0);
    add_item(3, 1'b0);
    add_item(2, 1'b0);
    add_item(2, 1'b0);
    add_item(1, 1'b0);
    add_item(1, 1'b1);
    add_item(1, 1'b0);
    add_item(2, 1'b0);
    add_item(3, 1'b0);
    add_item(4, 1'b1);

    // random lists; a few fill the store exactly or run past it
    total = 0;
    list_no = 0;
    while (total < RAND_ITEMS || list_no < 4) begin
      case (list_no)
        1:       len = MAX_ITEMS;
        2:       len = MAX_ITEMS + 1;
        3:       len = MAX_ITEMS + $urandom_range(2, 6);
        default: len = $urandom_range(0, 3) == 0 ? $urandom_range(13, 24)
                                                 : $urandom_range(1, 12);
      endcase
      for (int i = 0; i < len; i++) add_item(pick_value(), i == len - 1);
      total += len;
      list_no++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || sorted_expect.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("stable_rank_sorter regression: pass");
    end else begin
      $display("stable_rank_sorter regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/srs_pkg.sv
hdl/srs_cell.sv
hdl/stable_rank_sorter.sv
bench/stable_rank_sorter_tb.sv
